### rtl/dvru_pkg.sv
// Shared types and constants of the distance-vector route update core.
// Used by the top level and the shared cost unit; no dependencies.
`default_nettype none

package dvru_pkg;

    localparam int ID_W        = 8;
    localparam int FIELD_W     = 32;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [1:0] OP_VECTOR = 2'd0;
    localparam logic [1:0] OP_LINK   = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [APB_AW-3:0] REG_SELF_ID = 1'b0;

    typedef enum logic {
        ALU_ADD,
        ALU_CMP
    } alu_op_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } alu_flags_t;

endpackage

`default_nettype wire

### rtl/dvru_alu.sv
// Shared cost unit: saturating add or unsigned compare of two route costs.
// Depends on dvru_pkg for the operation code and flag types.
`default_nettype none

module dvru_alu #(
    parameter int COST_W = 32
) (
    input  dvru_pkg::alu_op_t    op,
    input  wire  [COST_W-1:0]    a,
    input  wire  [COST_W-1:0]    b,
    output logic [COST_W-1:0]    sum,
    output dvru_pkg::alu_flags_t flags
);
    import dvru_pkg::*;

    localparam logic [COST_W-1:0] UNREACH = '1;

    logic [COST_W:0] raw;

    always_comb begin
        raw   = {1'b0, a} + {1'b0, b};
        sum   = a;
        flags = '0;
        case (op)
            ALU_ADD: begin
                if (a == UNREACH || b == UNREACH || raw >= {1'b0, UNREACH}) begin
                    sum = UNREACH;
                end else begin
                    sum = raw[COST_W-1:0];
                end
            end
            ALU_CMP: begin
                flags.lt = (a < b);
                flags.eq = (a == b);
            end
            default: begin
                sum   = a;
                flags = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/distance_vector_route_update_core.sv
// Distance-vector routing table: top level with table memory and sequencer.
// Depends on dvru_pkg and dvru_alu.
//
// Usage:
//   Input channel (s_*): one transaction per operation. op 0 relaxes one
//   advertised vector entry, op 1 sets a direct link cost, op 2 looks up a
//   destination. Result channel (m_*): lookups, link updates and the last
//   entry of a changed vector give one result transaction.
//   The table is one memory with one read and one write port and
//   registered read data, and the saturating add and the compare share
//   one unit. A vector entry steps through read sender, read target,
//   add, then compare and write, and an output step when it produces an
//   announce. A lookup reads, loads and outputs; a link update writes and
//   outputs. s_ready is high only while the sequencer is idle.
//   Reset and a write of self_id start a clearing pass that rewrites
//   every entry (self entry valid at cost 0); no item is accepted
//   meanwhile. APB writes are taken at any time.
//   A stalled receiver holds the result in the output register; the next
//   item is still accepted, and its result waits until the register frees.
`default_nettype none

module distance_vector_route_update_core #(
    parameter int NODE_COUNT = 256,
    parameter int COST_WIDTH = 32
) (
    input  wire                          aclk,
    input  wire                          aresetn,

    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [dvru_pkg::APB_AW-1:0]  paddr,
    input  wire  [dvru_pkg::APB_DW-1:0]  pwdata,
    output logic [dvru_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,

    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [1:0]                   s_op,
    input  wire  [dvru_pkg::ID_W-1:0]    s_sender_id,
    input  wire  [dvru_pkg::ID_W-1:0]    s_node_id,
    input  wire  [dvru_pkg::FIELD_W-1:0] s_cost,
    input  wire  [dvru_pkg::FIELD_W-1:0] s_sender_reach_cost,
    input  wire                          s_last,

    output logic                         m_valid,
    input  wire                          m_ready,
    output logic                         m_found,
    output logic [dvru_pkg::ID_W-1:0]    m_next_hop,
    output logic [dvru_pkg::FIELD_W-1:0] m_route_cost,
    output logic                         m_announce
);
    import dvru_pkg::*;

    localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam logic [COST_WIDTH-1:0] COST_UNREACH = '1;

    typedef struct packed {
        logic                  valid;
        logic [ID_W-1:0]       hop;
        logic [COST_WIDTH-1:0] cost;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_V_SND,
        ST_V_ADD,
        ST_V_CMP,
        ST_L_DATA,
        ST_OUT
    } state_t;

    function automatic logic id_in_range(input logic [ID_W-1:0] id);
        return 32'(id) < NODE_COUNT;
    endfunction

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [ID_W-1:0]       self_id_reg, self_id_next;
    logic                  changed_reg, changed_next;
    logic [ID_W-1:0]       snd_reg, snd_next;
    logic [ID_W-1:0]       tgt_reg, tgt_next;
    logic [COST_WIDTH-1:0] adv_reg, adv_next;
    logic [COST_WIDTH-1:0] reach_reg, reach_next;
    logic                  last_reg, last_next;
    logic [COST_WIDTH-1:0] s_cost_reg, s_cost_next;
    logic [COST_WIDTH-1:0] t_reg, t_next;
    logic                  res_found_reg, res_found_next;
    logic [ID_W-1:0]       res_hop_reg, res_hop_next;
    logic [FIELD_W-1:0]    res_cost_reg, res_cost_next;
    logic                  res_ann_reg, res_ann_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_found_reg, m_found_next;
    logic [ID_W-1:0]       m_hop_reg, m_hop_next;
    logic [FIELD_W-1:0]    m_cost_reg, m_cost_next;
    logic                  m_ann_reg, m_ann_next;

    entry_t                mem [NODE_COUNT];
    entry_t                rd_q;
    logic                  mem_we, mem_re;
    logic [IDX_W-1:0]      mem_wa, mem_ra;
    entry_t                mem_wd;

    alu_op_t               alu_op;
    logic [COST_WIDTH-1:0] alu_a, alu_b, alu_sum;
    alu_flags_t            alu_flags;

    logic                  cfg_wr;
    logic                  upd;
    logic                  chg;

    dvru_alu #(
        .COST_W (COST_WIDTH)
    ) u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .sum   (alu_sum),
        .flags (alu_flags)
    );

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (paddr[APB_AW-1:2] == REG_SELF_ID) ? APB_DW'(self_id_reg) : '0;
    assign s_ready = (state_reg == ST_IDLE);

    assign m_valid      = m_valid_reg;
    assign m_found      = m_found_reg;
    assign m_next_hop   = m_hop_reg;
    assign m_route_cost = m_cost_reg;
    assign m_announce   = m_ann_reg;

    always_comb begin
        alu_op = (state_reg == ST_V_CMP) ? ALU_CMP : ALU_ADD;
        alu_a  = (state_reg == ST_V_CMP) ? t_reg : adv_reg;
        alu_b  = (state_reg == ST_V_CMP) ? rd_q.cost : s_cost_reg;
    end

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        self_id_next   = self_id_reg;
        changed_next   = changed_reg;
        snd_next       = snd_reg;
        tgt_next       = tgt_reg;
        adv_next       = adv_reg;
        reach_next     = reach_reg;
        last_next      = last_reg;
        s_cost_next    = s_cost_reg;
        t_next         = t_reg;
        res_found_next = res_found_reg;
        res_hop_next   = res_hop_reg;
        res_cost_next  = res_cost_reg;
        res_ann_next   = res_ann_reg;
        m_valid_next   = m_valid_reg;
        m_found_next   = m_found_reg;
        m_hop_next     = m_hop_reg;
        m_cost_next    = m_cost_reg;
        m_ann_next     = m_ann_reg;
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_wd         = '0;
        mem_re         = 1'b0;
        mem_ra         = '0;
        upd            = 1'b0;
        chg            = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = clr_cnt_reg;
                if (32'(clr_cnt_reg) == 32'(self_id_reg)) begin
                    mem_wd = '{valid: 1'b1, hop: self_id_reg, cost: '0};
                end else begin
                    mem_wd = '{valid: 1'b0, hop: '0, cost: COST_UNREACH};
                end
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(NODE_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    snd_next       = s_sender_id;
                    tgt_next       = s_node_id;
                    adv_next       = COST_WIDTH'(s_cost);
                    reach_next     = COST_WIDTH'(s_sender_reach_cost);
                    last_next      = s_last;
                    res_found_next = 1'b0;
                    res_hop_next   = '0;
                    res_cost_next  = '0;
                    res_ann_next   = 1'b0;
                    case (s_op)
                        OP_VECTOR: begin
                            if (id_in_range(s_sender_id) && id_in_range(s_node_id)) begin
                                mem_re     = 1'b1;
                                mem_ra     = IDX_W'(s_sender_id);
                                state_next = ST_V_SND;
                            end else if (s_last) begin
                                changed_next = 1'b0;
                                if (changed_reg) begin
                                    res_ann_next = 1'b1;
                                    state_next   = ST_OUT;
                                end
                            end
                        end
                        OP_LINK: begin
                            if (id_in_range(s_node_id) && s_node_id != self_id_reg) begin
                                mem_we       = 1'b1;
                                mem_wa       = IDX_W'(s_node_id);
                                mem_wd       = '{valid: 1'b1, hop: s_node_id,
                                                 cost: COST_WIDTH'(s_cost)};
                                res_ann_next = 1'b1;
                                state_next   = ST_OUT;
                            end
                        end
                        OP_LOOKUP: begin
                            if (id_in_range(s_node_id)) begin
                                mem_re     = 1'b1;
                                mem_ra     = IDX_W'(s_node_id);
                                state_next = ST_L_DATA;
                            end else begin
                                res_cost_next = FIELD_W'(COST_UNREACH);
                                state_next    = ST_OUT;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_V_SND: begin
                if (!rd_q.valid) begin
                    mem_we       = 1'b1;
                    mem_wa       = IDX_W'(snd_reg);
                    mem_wd       = '{valid: 1'b1, hop: snd_reg, cost: reach_reg};
                    s_cost_next  = reach_reg;
                    changed_next = 1'b1;
                end else begin
                    s_cost_next  = rd_q.cost;
                end
                mem_re     = 1'b1;
                mem_ra     = IDX_W'(tgt_reg);
                state_next = ST_V_ADD;
            end
            ST_V_ADD: begin
                t_next     = alu_sum;
                state_next = ST_V_CMP;
            end
            ST_V_CMP: begin
                upd = (tgt_reg != snd_reg) &&
                      (!rd_q.valid || alu_flags.lt ||
                       (!alu_flags.eq && rd_q.hop == snd_reg));
                if (upd) begin
                    mem_we = 1'b1;
                    mem_wa = IDX_W'(tgt_reg);
                    mem_wd = '{valid: 1'b1, hop: snd_reg, cost: t_reg};
                end
                chg = changed_reg || upd;
                if (last_reg) begin
                    changed_next = 1'b0;
                    if (chg) begin
                        res_ann_next = 1'b1;
                        state_next   = ST_OUT;
                    end else begin
                        state_next   = ST_IDLE;
                    end
                end else begin
                    changed_next = chg;
                    state_next   = ST_IDLE;
                end
            end
            ST_L_DATA: begin
                res_found_next = rd_q.valid;
                res_hop_next   = rd_q.valid ? rd_q.hop : '0;
                res_cost_next  = rd_q.valid ? FIELD_W'(rd_q.cost) : FIELD_W'(COST_UNREACH);
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_found_next = res_found_reg;
                    m_hop_next   = res_hop_reg;
                    m_cost_next  = res_cost_reg;
                    m_ann_next   = res_ann_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase

        if (cfg_wr && paddr[APB_AW-1:2] == REG_SELF_ID) begin
            self_id_next = pwdata[ID_W-1:0];
            changed_next = 1'b0;
            clr_cnt_next = '0;
            state_next   = ST_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            self_id_reg <= '0;
            changed_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            self_id_reg <= self_id_next;
            changed_reg <= changed_next;
            m_valid_reg <= m_valid_next;
        end
        snd_reg       <= snd_next;
        tgt_reg       <= tgt_next;
        adv_reg       <= adv_next;
        reach_reg     <= reach_next;
        last_reg      <= last_next;
        s_cost_reg    <= s_cost_next;
        t_reg         <= t_next;
        res_found_reg <= res_found_next;
        res_hop_reg   <= res_hop_next;
        res_cost_reg  <= res_cost_next;
        res_ann_reg   <= res_ann_next;
        m_found_reg   <= m_found_next;
        m_hop_reg     <= m_hop_next;
        m_cost_reg    <= m_cost_next;
        m_ann_reg     <= m_ann_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_q <= mem[mem_ra];
        end
    end

endmodule

`default_nettype wire

### rtl/dvru_checker.sv
// Port-level checker for the distance-vector route update core, bound to it.
// Depends only on the ports of distance_vector_route_update_core.
`default_nettype none

module dvru_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        psel,
    input wire        penable,
    input wire        pwrite,
    input wire        s_ready,
    input wire        m_valid,
    input wire        m_ready,
    input wire        m_found,
    input wire [7:0]  m_next_hop,
    input wire [31:0] m_route_cost,
    input wire        m_announce
);

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("core ready or result pending right after reset");

    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite |=> !s_ready)
        else $error("input taken during table clearing after self_id write");

    a_announce_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_announce |-> !m_found && m_next_hop == 8'd0 && m_route_cost == 32'd0)
        else $error("announce transaction carries lookup fields");

    a_miss_hop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_next_hop == 8'd0)
        else $error("lookup miss with nonzero next hop");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_route_cost) && $stable(m_next_hop))
        else $error("result transaction dropped or changed while stalled");

endmodule

bind distance_vector_route_update_core dvru_checker u_dvru_checker (.*);

`default_nettype wire

### tb/distance_vector_route_update_core_tb.sv
// Testbench for distance_vector_route_update_core: directed and random route traffic,
// checked against a local routing-table predictor. Depends on dvru_pkg and the core RTL.
`timescale 1ns / 100ps

module distance_vector_route_update_core_tb;
    import dvru_pkg::*;

    localparam int NODES        = 256;
    localparam int POOL_SIZE    = 10;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_SETTLE = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [FIELD_W-1:0] COST_UNREACH = '1;
    localparam logic [APB_AW-1:0] SELF_ID_ADDR = {REG_SELF_ID, 2'b00};

    typedef struct packed {
        logic [1:0]         op;
        logic [ID_W-1:0]    sender_id;
        logic [ID_W-1:0]    node_id;
        logic [FIELD_W-1:0] cost;
        logic [FIELD_W-1:0] reach;
        logic               last;
    } route_req_t;

    typedef struct packed {
        logic               found;
        logic [ID_W-1:0]    next_hop;
        logic [FIELD_W-1:0] route_cost;
        logic               announce;
    } route_resp_t;

    logic aclk = 1'b0;
    logic aresetn;

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    logic                s_valid;
    logic                s_ready;
    logic [1:0]          s_op;
    logic [ID_W-1:0]     s_sender_id;
    logic [ID_W-1:0]     s_node_id;
    logic [FIELD_W-1:0]  s_cost;
    logic [FIELD_W-1:0]  s_sender_reach_cost;
    logic                s_last;

    logic                m_valid;
    logic                m_ready;
    logic                m_found;
    logic [ID_W-1:0]     m_next_hop;
    logic [FIELD_W-1:0]  m_route_cost;
    logic                m_announce;

    logic                tbl_valid [NODES];
    logic [FIELD_W-1:0]  tbl_cost [NODES];
    logic [ID_W-1:0]     tbl_hop [NODES];
    logic                vec_changed;
    logic [ID_W-1:0]     my_id;
    logic [ID_W-1:0]     node_pool [POOL_SIZE];

    route_resp_t         expected_results [$];
    route_resp_t         want_resp;
    int                  mismatches = 0;
    bit                  tx_idle_en = 1'b1;
    bit                  rx_idle_en = 1'b1;
    bit                  hold_output = 1'b0;

    distance_vector_route_update_core #(
        .NODE_COUNT (NODES),
        .COST_WIDTH (FIELD_W)
    ) u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_op                (s_op),
        .s_sender_id         (s_sender_id),
        .s_node_id           (s_node_id),
        .s_cost              (s_cost),
        .s_sender_reach_cost (s_sender_reach_cost),
        .s_last              (s_last),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_found             (m_found),
        .m_next_hop          (m_next_hop),
        .m_route_cost        (m_route_cost),
        .m_announce          (m_announce)
    );

    always #6 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    function automatic logic [FIELD_W-1:0] sat_add(input logic [FIELD_W-1:0] a,
                                                   input logic [FIELD_W-1:0] b);
        logic [FIELD_W:0] sum;
        if (a == COST_UNREACH || b == COST_UNREACH) return COST_UNREACH;
        sum = {1'b0, a} + {1'b0, b};
        return (sum >= {1'b0, COST_UNREACH}) ? COST_UNREACH : sum[FIELD_W-1:0];
    endfunction

    function automatic void clear_table(input logic [ID_W-1:0] id);
        for (int i = 0; i < NODES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_cost[i]  = COST_UNREACH;
            tbl_hop[i]   = '0;
        end
        tbl_valid[id] = 1'b1;
        tbl_cost[id]  = '0;
        tbl_hop[id]   = id;
        vec_changed   = 1'b0;
        my_id         = id;
    endfunction

    function automatic void set_route(input logic [ID_W-1:0] idx, input logic [FIELD_W-1:0] c,
                                      input logic [ID_W-1:0] hop);
        tbl_valid[idx] = 1'b1;
        tbl_cost[idx]  = c;
        tbl_hop[idx]   = hop;
    endfunction

    function automatic void relax_route(input logic [ID_W-1:0] snd, input logic [ID_W-1:0] tgt,
                                        input logic [FIELD_W-1:0] adv,
                                        input logic [FIELD_W-1:0] reach);
        logic [FIELD_W-1:0] via;
        if (!tbl_valid[snd]) begin
            set_route(snd, reach, snd);
            vec_changed = 1'b1;
        end
        via = sat_add(adv, tbl_cost[snd]);
        if (!tbl_valid[tgt]) begin
            set_route(tgt, via, snd);
            vec_changed = 1'b1;
        end else if (tgt != snd) begin
            if (via < tbl_cost[tgt] || (via != tbl_cost[tgt] && tbl_hop[tgt] == snd)) begin
                set_route(tgt, via, snd);
                vec_changed = 1'b1;
            end
        end
    endfunction

    function automatic void apply_route_req(input route_req_t r);
        route_resp_t resp;
        resp = '0;
        case (r.op)
            OP_VECTOR: begin
                relax_route(r.sender_id, r.node_id, r.cost, r.reach);
                if (r.last) begin
                    if (vec_changed) begin
                        resp.announce = 1'b1;
                        expected_results.push_back(resp);
                    end
                    vec_changed = 1'b0;
                end
            end
            OP_LINK: begin
                if (r.node_id != my_id) begin
                    set_route(r.node_id, r.cost, r.node_id);
                    resp.announce = 1'b1;
                    expected_results.push_back(resp);
                end
            end
            OP_LOOKUP: begin
                if (tbl_valid[r.node_id]) begin
                    resp.found      = 1'b1;
                    resp.next_hop   = tbl_hop[r.node_id];
                    resp.route_cost = tbl_cost[r.node_id];
                end else begin
                    resp.route_cost = COST_UNREACH;
                end
                expected_results.push_back(resp);
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- drivers

    function automatic route_req_t make_req(input logic [1:0] op, input logic [ID_W-1:0] snd,
                                            input logic [ID_W-1:0] node,
                                            input logic [FIELD_W-1:0] c,
                                            input logic [FIELD_W-1:0] reach, input logic last);
        route_req_t r;
        r.op        = op;
        r.sender_id = snd;
        r.node_id   = node;
        r.cost      = c;
        r.reach     = reach;
        r.last      = last;
        return r;
    endfunction

    task automatic send_req(input route_req_t r);
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_op                <= r.op;
        s_sender_id         <= r.sender_id;
        s_node_id           <= r.node_id;
        s_cost              <= r.cost;
        s_sender_reach_cost <= r.reach;
        s_last              <= r.last;
        do @(posedge aclk); while (!s_ready);
        apply_route_req(r);
    endtask

    // Drop valid, then hold until every pending result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_SETTLE) @(posedge aclk);
    endtask

    task automatic write_self_id(input logic [ID_W-1:0] id);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SELF_ID_ADDR;
        pwdata  <= APB_DW'(id);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        clear_table(id);
    endtask

    function automatic logic [FIELD_W-1:0] pick_cost();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return COST_UNREACH;
            2:       return $urandom_range(32'hFFFF_FF00, 32'hFFFF_FFFE);
            3:       return $urandom();
            default: return $urandom_range(0, 32'h0000_3000);
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_node();
        if ($urandom_range(0, 3) != 0) return node_pool[$urandom_range(0, POOL_SIZE - 1)];
        return ID_W'($urandom_range(0, NODES - 1));
    endfunction

    // ---------------------------------------------------------------- checker

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with no expected result pending");
                mismatches++;
            end else begin
                want_resp = expected_results.pop_front();
                if (m_found !== want_resp.found) begin
                    $error("found: expected %0h, actual %0h", want_resp.found, m_found);
                    mismatches++;
                end
                if (m_next_hop !== want_resp.next_hop) begin
                    $error("next_hop: expected %0h, actual %0h", want_resp.next_hop, m_next_hop);
                    mismatches++;
                end
                if (m_route_cost !== want_resp.route_cost) begin
                    $error("route_cost: expected %0h, actual %0h",
                           want_resp.route_cost, m_route_cost);
                    mismatches++;
                end
                if (m_announce !== want_resp.announce) begin
                    $error("announce: expected %0h, actual %0h", want_resp.announce, m_announce);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int span;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_output) begin
                m_ready     <= 1'b0;
                span        = LONG_HOLD;
                hold_output = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                span    = $urandom_range(1, 8);
            end else begin
                m_ready <= 1'b1;
                span    = $urandom_range(1, 12);
            end
            repeat (span) @(posedge aclk);
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_reset_state();
        send_req(make_req(OP_LOOKUP, 8'd0, 8'd0, '0, '0, 1'b0));
        send_req(make_req(OP_LOOKUP, 8'd0, 8'd255, '0, '0, 1'b0));
        send_req(make_req(OP_LOOKUP, 8'd0, 8'd1, '0, '0, 1'b0));
        drain_results();
    endtask

    task automatic test_directed_ops();
        write_self_id(8'd0);
        send_req(make_req(OP_LINK, 8'd0, 8'd0, 32'd5, '0, 1'b0));
        send_req(make_req(OP_UNUSED, 8'hFF, 8'hFF, '1, '1, 1'b1));
        send_req(make_req(OP_LINK, 8'd0, 8'd7, 32'h100, '0, 1'b0));
        send_req(make_req(OP_LINK, 8'd0, 8'd255, COST_UNREACH, '0, 1'b0));
        send_req(make_req(OP_VECTOR, 8'd9, 8'd200, 32'h10, 32'h500, 1'b0));
        send_req(make_req(OP_VECTOR, 8'd7, 8'd200, 32'h80, '0, 1'b1));
        send_req(make_req(OP_VECTOR, 8'd7, 8'd7, 32'h0, '0, 1'b1));
        send_req(make_req(OP_VECTOR, 8'd7, 8'd4, 32'hFFFF_FF00, '0, 1'b0));
        send_req(make_req(OP_VECTOR, 8'd7, 8'd0, 32'h0, '0, 1'b1));
        send_req(make_req(OP_VECTOR, 8'd7, 8'd200, 32'h400, '0, 1'b1));
        send_req(make_req(OP_VECTOR, 8'd9, 8'd200, 32'h10, '0, 1'b1));
        send_req(make_req(OP_VECTOR, 8'd255, 8'd3, 32'h0, '0, 1'b1));
        send_req(make_req(OP_VECTOR, 8'd0, 8'd50, 32'hFFFF_FFFE, '1, 1'b1));
        send_req(make_req(OP_LINK, 8'd0, 8'd7, 32'h0, '0, 1'b0));
        foreach (node_pool[i]) node_pool[i] = '0;
        send_req(make_req(OP_LOOKUP, 8'd0, 8'd200, '0, '0, 1'b0));
        send_req(make_req(OP_LOOKUP, 8'd0, 8'd4, '0, '0, 1'b0));
        send_req(make_req(OP_LOOKUP, 8'd0, 8'd3, '0, '0, 1'b0));
        send_req(make_req(OP_LOOKUP, 8'd0, 8'd9, '0, '0, 1'b0));
        send_req(make_req(OP_LOOKUP, 8'd0, 8'd255, '0, '0, 1'b0));
        send_req(make_req(OP_LOOKUP, 8'd0, 8'd50, '0, '0, 1'b0));
        send_req(make_req(OP_LOOKUP, 8'd0, 8'd7, '0, '0, 1'b0));
        drain_results();
    endtask

    task automatic test_self_id_config();
        write_self_id(8'd255);
        send_req(make_req(OP_LOOKUP, 8'd0, 8'd255, '0, '0, 1'b0));
        send_req(make_req(OP_LOOKUP, 8'd0, 8'd0, '0, '0, 1'b0));
        send_req(make_req(OP_LINK, 8'd0, 8'd255, 32'h40, '0, 1'b0));
        send_req(make_req(OP_VECTOR, 8'd255, 8'd255, 32'h40, 32'h40, 1'b1));
        send_req(make_req(OP_VECTOR, 8'd12, 8'd255, 32'h0, 32'h0, 1'b1));
        send_req(make_req(OP_LOOKUP, 8'd0, 8'd255, '0, '0, 1'b0));
        drain_results();
    endtask

    task automatic test_output_stall();
        bit saved_idle;
        saved_idle  = tx_idle_en;
        tx_idle_en  = 1'b0;
        hold_output = 1'b1;
        while (hold_output) @(posedge aclk);
        for (int i = 0; i < 30; i++) begin
            if (i % 3 == 0)
                send_req(make_req(OP_LINK, 8'd0, 8'(i + 1), pick_cost(), '0, 1'b0));
            else
                send_req(make_req(OP_LOOKUP, 8'd0, 8'($urandom_range(0, 40)), '0, '0, 1'b0));
        end
        drain_results();
        tx_idle_en = saved_idle;
    endtask

    task automatic test_random_routes(input int item_count, input logic [ID_W-1:0] id);
        int                 sent;
        int                 sel;
        int                 span;
        logic [ID_W-1:0]    snd;
        write_self_id(id);
        node_pool[0] = id;
        node_pool[1] = 8'd0;
        node_pool[2] = 8'd255;
        for (int i = 3; i < POOL_SIZE; i++) node_pool[i] = ID_W'($urandom_range(0, NODES - 1));
        sent = 0;
        while (sent < item_count) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                snd  = pick_node();
                span = $urandom_range(1, 5);
                for (int j = 0; j < span; j++) begin
                    send_req(make_req(OP_VECTOR, snd, pick_node(), pick_cost(), pick_cost(),
                                      j == span - 1));
                    sent++;
                end
            end else if (sel < 75) begin
                send_req(make_req(OP_LOOKUP, pick_node(), pick_node(), $urandom(), $urandom(),
                                  1'($urandom_range(0, 1))));
                sent++;
            end else if (sel < 85) begin
                send_req(make_req(OP_LINK, pick_node(), pick_node(), pick_cost(), $urandom(),
                                  1'($urandom_range(0, 1))));
                sent++;
            end else begin
                send_req(make_req(2'($urandom_range(0, 3)), 8'($urandom()), 8'($urandom()),
                                  $urandom(), $urandom(), 1'($urandom_range(0, 1))));
                sent++;
            end
        end
        drain_results();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        aresetn             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        s_valid             <= 1'b0;
        s_op                <= '0;
        s_sender_id         <= '0;
        s_node_id           <= '0;
        s_cost              <= '0;
        s_sender_reach_cost <= '0;
        s_last              <= 1'b0;
        clear_table(8'd0);
        foreach (node_pool[i]) node_pool[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_directed_ops();
        test_self_id_config();
        test_output_stall();
        test_random_routes(250, 8'd255);
        test_random_routes(250, 8'($urandom_range(1, 254)));
        test_random_routes(250, 8'd0);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_routes(250, 8'($urandom_range(1, 254)));

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

### distance_vector_route_update_core.f
rtl/dvru_pkg.sv
rtl/dvru_alu.sv
rtl/distance_vector_route_update_core.sv
rtl/dvru_checker.sv
tb/distance_vector_route_update_core_tb.sv
